// ----- rtl/core/forth_data_stack_core_macros.svh -----
// Assertion helpers for the stack checker
`ifndef FORTH_DATA_STACK_CORE_MACROS_SVH
`define FORTH_DATA_STACK_CORE_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define FDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stack check failed");

// Next-cycle implication, off while reset is asserted
`define FDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stack check failed");

`endif

// ----- rtl/core/fds_pkg.sv -----
`timescale 1ns / 1ps

package fds_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = $clog2(DEPTH);

  typedef enum logic [2:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_PICK   = 3'd2,
    MODE_ROLL   = 3'd3,
    MODE_WR_TOP = 3'd4,
    MODE_WR_SEC = 3'd5,
    MODE_SET_SP = 3'd6,
    MODE_CLEAR  = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // What a cell loads at the next edge
  typedef enum logic [2:0] {
    SEL_HOLD,
    SEL_LOAD,
    SEL_UP,
    SEL_DOWN,
    SEL_BCAST
  } cell_sel_e;

  typedef logic [WORD_W-1:0]            word_t;
  typedef logic [DEPTH-1:0][WORD_W-1:0] word_arr_t;
  typedef cell_sel_e                    sel_arr_t [DEPTH];

  typedef struct packed {
    word_t            rd;
    status_e          status;
    logic [CNT_W-1:0] sp_d;
  } ctrl_res_t;

endpackage

// ----- rtl/core/fds_if.sv -----
`timescale 1ns / 1ps

interface fds_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic [31:0]       value;
  logic [3:0]        offset;
  logic signed [4:0] roll_count;
  logic [4:0]        new_depth;

  modport source (output valid, mode, value, offset, roll_count, new_depth, input ready);
  modport sink   (input valid, mode, value, offset, roll_count, new_depth, output ready);
endinterface

interface fds_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [31:0] top_word;
  logic [31:0] second_word;
  logic [4:0]  depth;
  logic [1:0]  status;

  modport source (output valid, read_data, top_word, second_word, depth, status, input ready);
  modport sink   (input valid, read_data, top_word, second_word, depth, status, output ready);
endinterface

// ----- rtl/core/forth_data_stack_core.sv -----
// Forth data stack: a row of word cells, bottom entry in cell zero.
// A result beat is held in a pending register, then the response register.
// Throughput: one command per cycle unless the result side stalls; roll moves
// all window cells at once, pop, pick and roll read through one cell select.
// Reset clears depth and the result pipeline; cell contents stay undefined.
`timescale 1ns / 1ps

module forth_data_stack_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  fds_in_if.sink     cmd_i,
  fds_out_if.source  rsp_o
);

  localparam int CW = fds_pkg::CNT_W;
  localparam int IW = fds_pkg::IDX_W;

  fds_pkg::word_arr_t words;
  fds_pkg::sel_arr_t  sel;
  fds_pkg::word_t     bcast;
  fds_pkg::ctrl_res_t res;

  logic [CW-1:0]      sp_q;
  logic               pend_q, rsp_valid_q;
  fds_pkg::word_t     pend_rd_q;
  fds_pkg::status_e   pend_st_q;
  fds_pkg::word_t     rsp_rd_q, rsp_top_q, rsp_sec_q;
  logic [CW-1:0]      rsp_sp_q;
  fds_pkg::status_e   rsp_st_q;
  fds_pkg::word_t     top_w, sec_w;
  logic               fire, pend_move;
  logic [CW-1:0]      top_idx, sec_idx;

  // Handshake: a pending beat moves on when the result slot frees up
  assign pend_move   = pend_q && (!rsp_valid_q || rsp_o.ready);
  assign cmd_i.ready = !pend_q || pend_move;
  assign fire        = cmd_i.valid && cmd_i.ready;

  fds_ctrl u_ctrl (
    .fire_i       (fire),
    .mode_i       (cmd_i.mode),
    .offset_i     (cmd_i.offset),
    .roll_count_i (cmd_i.roll_count),
    .new_depth_i  (cmd_i.new_depth),
    .sp_i         (sp_q),
    .words_i      (words),
    .sel_o        (sel),
    .bcast_o      (bcast),
    .res_o        (res)
  );

  // Row of cells, each wired to its neighbors
  for (genvar i = 0; i < fds_pkg::DEPTH; i++) begin : g_cell
    fds_pkg::word_t up_w, dn_w;
    if (i == fds_pkg::DEPTH - 1) begin : g_last
      assign up_w = words[i];
    end else begin : g_up
      assign up_w = words[i+1];
    end
    if (i == 0) begin : g_first
      assign dn_w = words[i];
    end else begin : g_dn
      assign dn_w = words[i-1];
    end
    fds_cell u_cell (
      .clk_i   (clk_i),
      .sel_i   (sel[i]),
      .load_i  (cmd_i.value),
      .bcast_i (bcast),
      .up_i    (up_w),
      .dn_i    (dn_w),
      .word_o  (words[i])
    );
  end

  // Top and second of the settled stack
  always_comb begin
    top_idx = sp_q - CW'(1);
    sec_idx = sp_q - CW'(2);
    top_w   = (sp_q >= CW'(1)) ? words[top_idx[IW-1:0]] : '0;
    sec_w   = (sp_q >= CW'(2)) ? words[sec_idx[IW-1:0]] : '0;
  end

  // Depth and beat valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (fire) sp_q <= res.sp_d;
      if (fire) pend_q <= 1'b1;
      else if (pend_move) pend_q <= 1'b0;
      if (pend_move) rsp_valid_q <= 1'b1;
      else if (rsp_o.ready) rsp_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      pend_rd_q <= res.rd;
      pend_st_q <= res.status;
    end
    if (pend_move) begin
      rsp_rd_q  <= pend_rd_q;
      rsp_st_q  <= pend_st_q;
      rsp_top_q <= top_w;
      rsp_sec_q <= sec_w;
      rsp_sp_q  <= sp_q;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.read_data   = rsp_rd_q;
  assign rsp_o.top_word    = rsp_top_q;
  assign rsp_o.second_word = rsp_sec_q;
  assign rsp_o.depth       = 5'(rsp_sp_q);
  assign rsp_o.status      = rsp_st_q;

endmodule

// ----- rtl/core/fds_cell.sv -----
`timescale 1ns / 1ps

module fds_cell (
  input  logic                clk_i,
  input  fds_pkg::cell_sel_e  sel_i,
  input  fds_pkg::word_t      load_i,
  input  fds_pkg::word_t      bcast_i,
  input  fds_pkg::word_t      up_i,
  input  fds_pkg::word_t      dn_i,
  output fds_pkg::word_t      word_o
);

  fds_pkg::word_t word_q, word_d;

  // Pick the source for this entry
  always_comb begin
    case (sel_i)
      fds_pkg::SEL_LOAD:  word_d = load_i;
      fds_pkg::SEL_UP:    word_d = up_i;
      fds_pkg::SEL_DOWN:  word_d = dn_i;
      fds_pkg::SEL_BCAST: word_d = bcast_i;
      default:            word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ----- rtl/core/fds_ctrl.sv -----
`timescale 1ns / 1ps

module fds_ctrl (
  input  logic                         fire_i,
  input  logic [2:0]                   mode_i,
  input  logic [3:0]                   offset_i,
  input  logic signed [4:0]            roll_count_i,
  input  logic [4:0]                   new_depth_i,
  input  logic [fds_pkg::CNT_W-1:0]    sp_i,
  input  fds_pkg::word_arr_t           words_i,
  output fds_pkg::sel_arr_t            sel_o,
  output fds_pkg::word_t               bcast_o,
  output fds_pkg::ctrl_res_t           res_o
);

  localparam int CW = fds_pkg::CNT_W;
  localparam int IW = fds_pkg::IDX_W;

  logic [4:0]    mag;
  logic [CW-1:0] mag_c, top_idx, lo_idx, pick_idx, rd_idx;
  logic          roll_pos, roll_neg, roll_bad;
  logic          sp_full;

  // Roll magnitude and window bounds
  always_comb begin
    mag      = roll_count_i[4] ? (~roll_count_i + 5'd1) : roll_count_i;
    mag_c    = CW'(mag);
    top_idx  = sp_i - CW'(1);
    lo_idx   = top_idx - mag_c;
    pick_idx = top_idx - CW'(offset_i);
    roll_pos = (roll_count_i != '0) && !roll_count_i[4];
    roll_neg = roll_count_i[4];
    roll_bad = (roll_count_i != '0) && (CW'(mag) >= sp_i || mag > 5'(fds_pkg::DEPTH - 1));
    sp_full  = (sp_i >= CW'(fds_pkg::DEPTH));
  end

  // Shared read select: popped, picked or carried word
  always_comb begin
    case (fds_pkg::mode_e'(mode_i))
      fds_pkg::MODE_PICK: rd_idx = pick_idx;
      fds_pkg::MODE_ROLL: rd_idx = roll_neg ? top_idx : lo_idx;
      default:            rd_idx = top_idx;
    endcase
    bcast_o = words_i[rd_idx[IW-1:0]];
  end

  // Decode the operation into a status, a depth and per-cell moves
  always_comb begin
    res_o.rd     = '0;
    res_o.status = fds_pkg::ST_OK;
    res_o.sp_d   = sp_i;
    for (int i = 0; i < fds_pkg::DEPTH; i++) begin
      sel_o[i] = fds_pkg::SEL_HOLD;
    end
    unique case (fds_pkg::mode_e'(mode_i))
      fds_pkg::MODE_PUSH: begin
        if (sp_full) begin
          res_o.status = fds_pkg::ST_OVER;
        end else begin
          res_o.sp_d = sp_i + CW'(1);
          for (int i = 0; i < fds_pkg::DEPTH; i++) begin
            if (CW'(i) == sp_i) sel_o[i] = fds_pkg::SEL_LOAD;
          end
        end
      end
      fds_pkg::MODE_POP: begin
        if (sp_i == '0) begin
          res_o.status = fds_pkg::ST_UNDER;
        end else begin
          res_o.sp_d = top_idx;
          res_o.rd   = bcast_o;
        end
      end
      fds_pkg::MODE_PICK: begin
        if (sp_i == '0) begin
          res_o.status = fds_pkg::ST_UNDER;
        end else if (CW'(offset_i) >= sp_i) begin
          res_o.status = fds_pkg::ST_RANGE;
        end else begin
          res_o.rd = bcast_o;
        end
      end
      fds_pkg::MODE_ROLL: begin
        if (roll_bad) begin
          res_o.status = fds_pkg::ST_RANGE;
        end else begin
          for (int i = 0; i < fds_pkg::DEPTH; i++) begin
            if (roll_pos) begin
              if (CW'(i) == top_idx) sel_o[i] = fds_pkg::SEL_BCAST;
              else if (CW'(i) >= lo_idx && CW'(i) < top_idx) sel_o[i] = fds_pkg::SEL_UP;
            end else if (roll_neg) begin
              if (CW'(i) == lo_idx) sel_o[i] = fds_pkg::SEL_BCAST;
              else if (CW'(i) > lo_idx && CW'(i) <= top_idx) sel_o[i] = fds_pkg::SEL_DOWN;
            end
          end
        end
      end
      fds_pkg::MODE_WR_TOP: begin
        if (sp_i < CW'(1)) begin
          res_o.status = fds_pkg::ST_UNDER;
        end else begin
          for (int i = 0; i < fds_pkg::DEPTH; i++) begin
            if (CW'(i) == top_idx) sel_o[i] = fds_pkg::SEL_LOAD;
          end
        end
      end
      fds_pkg::MODE_WR_SEC: begin
        if (sp_i < CW'(2)) begin
          res_o.status = fds_pkg::ST_UNDER;
        end else begin
          for (int i = 0; i < fds_pkg::DEPTH; i++) begin
            if (CW'(i) == sp_i - CW'(2)) sel_o[i] = fds_pkg::SEL_LOAD;
          end
        end
      end
      fds_pkg::MODE_SET_SP: begin
        if (new_depth_i > 5'(fds_pkg::DEPTH)) begin
          res_o.status = fds_pkg::ST_RANGE;
        end else begin
          res_o.sp_d = CW'(new_depth_i);
        end
      end
      fds_pkg::MODE_CLEAR: begin
        res_o.sp_d = '0;
      end
    endcase
    // Hold every cell unless a beat is taken
    if (!fire_i) begin
      for (int i = 0; i < fds_pkg::DEPTH; i++) begin
        sel_o[i] = fds_pkg::SEL_HOLD;
      end
    end
  end

endmodule

// ----- rtl/core/fds_checker.sv -----
`timescale 1ns / 1ps
`include "forth_data_stack_core_macros.svh"

module fds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] read_data_i,
  input logic [31:0] top_word_i,
  input logic [31:0] second_word_i,
  input logic [4:0]  depth_i,
  input logic [1:0]  status_i
);

  // A stalled result beat holds
  `FDS_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(read_data_i) && $stable(depth_i) && $stable(status_i))

  // Depth never passes capacity
  `FDS_ASSERT_IMPL(a_depth_max, clk_i, rst_ni, rsp_valid_i, depth_i <= 5'(fds_pkg::DEPTH))

  // Overflow only on a full stack
  `FDS_ASSERT_IMPL(a_over_full, clk_i, rst_ni, rsp_valid_i && status_i == fds_pkg::ST_OVER, depth_i == 5'(fds_pkg::DEPTH))

  // Shallow stack shows zero words
  `FDS_ASSERT_IMPL(a_shallow_zero, clk_i, rst_ni, rsp_valid_i && depth_i < 5'd2, second_word_i == '0 && (depth_i != '0 || top_word_i == '0))

  // Failed operations read nothing
  `FDS_ASSERT_IMPL(a_err_no_read, clk_i, rst_ni, rsp_valid_i && status_i != fds_pkg::ST_OK, read_data_i == '0)

endmodule

bind forth_data_stack_core fds_checker u_fds_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .read_data_i   (rsp_o.read_data),
  .top_word_i    (rsp_o.top_word),
  .second_word_i (rsp_o.second_word),
  .depth_i       (rsp_o.depth),
  .status_i      (rsp_o.status)
);

// ----- dv/forth_data_stack_core_tb.sv -----
`timescale 1ns / 1ps

module forth_data_stack_core_tb;
  import fds_pkg::*;

  // One stack command and the response it produces
  typedef struct packed {
    mode_e             mode;
    word_t             value;
    logic [3:0]        offset;
    logic signed [4:0] roll_count;
    logic [4:0]        new_depth;
  } stack_cmd_t;

  typedef struct packed {
    word_t            read_data;
    word_t            top_word;
    word_t            second_word;
    logic [CNT_W-1:0] depth;
    status_e          status;
  } stack_rsp_t;

  typedef struct packed {
    word_arr_t        entry;
    logic [CNT_W-1:0] sp;
  } stack_state_t;

  logic clk = 1'b0;
  logic rst_n;

  fds_in_if  cmd_if ();
  fds_out_if rsp_if ();

  forth_data_stack_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  always #2 clk = ~clk;

  stack_cmd_t   pend_q [$];
  stack_rsp_t   rsp_expect_q [$];
  stack_state_t model_st;
  stack_state_t gen_st;
  int           gen_written;
  int           send_idle_pct;
  int           recv_stall_pct;
  logic         long_hold;
  int           cmd_issued;
  int           rsp_checked;
  int           mismatch_cnt;
  int           status_seen [4];

  // Apply one command to a stack image and form its response
  function automatic void stack_apply(inout stack_state_t s, input stack_cmd_t c,
                                      output stack_rsp_t r);
    int    sp;
    int    cnt;
    int    mag;
    int    k;
    word_t held;
    sp  = int'(s.sp);
    cnt = int'(c.roll_count);
    mag = (cnt < 0) ? -cnt : cnt;
    r.read_data = '0;
    r.status    = ST_OK;
    case (c.mode)
      MODE_PUSH: begin
        if (sp >= DEPTH) r.status = ST_OVER;
        else begin
          s.entry[sp] = c.value;
          sp++;
        end
      end
      MODE_POP: begin
        if (sp == 0) r.status = ST_UNDER;
        else begin
          sp--;
          r.read_data = s.entry[sp];
        end
      end
      MODE_PICK: begin
        if (sp == 0) r.status = ST_UNDER;
        else if (int'(c.offset) >= sp) r.status = ST_RANGE;
        else r.read_data = s.entry[sp-1-int'(c.offset)];
      end
      MODE_ROLL: begin
        if (mag >= sp && cnt != 0) r.status = ST_RANGE;
        else if (cnt > 0) begin
          // raise the deep item, shift the ones above it down
          held = s.entry[sp-1-mag];
          for (k = sp - 1 - mag; k < sp - 1; k++) s.entry[k] = s.entry[k+1];
          s.entry[sp-1] = held;
        end else if (cnt < 0) begin
          // sink the top item
          held = s.entry[sp-1];
          for (k = sp - 1; k > sp - 1 - mag; k--) s.entry[k] = s.entry[k-1];
          s.entry[sp-1-mag] = held;
        end
      end
      MODE_WR_TOP: begin
        if (sp < 1) r.status = ST_UNDER;
        else s.entry[sp-1] = c.value;
      end
      MODE_WR_SEC: begin
        if (sp < 2) r.status = ST_UNDER;
        else s.entry[sp-2] = c.value;
      end
      MODE_SET_SP: begin
        if (int'(c.new_depth) > DEPTH) r.status = ST_RANGE;
        else sp = int'(c.new_depth);
      end
      MODE_CLEAR: sp = 0;
    endcase
    s.sp          = CNT_W'(sp);
    r.depth       = s.sp;
    r.top_word    = (sp >= 1) ? s.entry[sp-1] : '0;
    r.second_word = (sp >= 2) ? s.entry[sp-2] : '0;
  endfunction

  function automatic stack_cmd_t mk_cmd(mode_e mode, word_t value, int offset, int rc, int nd);
    stack_cmd_t c;
    c.mode       = mode;
    c.value      = value;
    c.offset     = offset[3:0];
    c.roll_count = rc[4:0];
    c.new_depth  = nd[4:0];
    return c;
  endfunction

  // Track the stimulus-side stack so no unwritten cell is ever exposed
  task automatic queue_cmd(input stack_cmd_t c);
    stack_rsp_t r;
    stack_apply(gen_st, c, r);
    if (int'(gen_st.sp) > gen_written) gen_written = int'(gen_st.sp);
    pend_q.push_back(c);
  endtask

  task automatic queue_dir(mode_e mode, word_t value, int offset, int rc, int nd);
    queue_cmd(mk_cmd(mode, value, offset, rc, nd));
  endtask

  task automatic queue_random(int n);
    stack_cmd_t c;
    int         sel;
    int         sp;
    int         rc;
    repeat (n) begin
      sp  = int'(gen_st.sp);
      sel = $urandom_range(99);
      c.value = $urandom;
      if (sel < 4) c.value = '0;
      else if (sel < 8) c.value = '1;
      // mostly in-range distances, the rest anywhere
      if (sp > 0 && $urandom_range(99) < 80) c.offset = 4'($urandom_range(sp - 1));
      else c.offset = 4'($urandom_range(15));
      if (sp > 0 && $urandom_range(99) < 80) rc = $urandom_range(sp - 1);
      else rc = $urandom_range(15);
      if ($urandom_range(1)) rc = -rc;
      c.roll_count = rc[4:0];
      if ($urandom_range(99) < 5) c.new_depth = 5'($urandom_range(31, DEPTH + 1));
      else c.new_depth = 5'($urandom_range(gen_written));
      sel = $urandom_range(99);
      if (sel < 30) c.mode = MODE_PUSH;
      else if (sel < 52) c.mode = MODE_POP;
      else if (sel < 64) c.mode = MODE_PICK;
      else if (sel < 78) c.mode = MODE_ROLL;
      else if (sel < 85) c.mode = MODE_WR_TOP;
      else if (sel < 92) c.mode = MODE_WR_SEC;
      else if (sel < 97) c.mode = MODE_SET_SP;
      else c.mode = MODE_CLEAR;
      queue_cmd(c);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Drive command beats; predict each one as it is taken
  always @(posedge clk) begin : cmd_driver
    stack_cmd_t c;
    stack_rsp_t r;
    if (!rst_n) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        c.mode       = mode_e'(cmd_if.mode);
        c.value      = cmd_if.value;
        c.offset     = cmd_if.offset;
        c.roll_count = cmd_if.roll_count;
        c.new_depth  = cmd_if.new_depth;
        stack_apply(model_st, c, r);
        rsp_expect_q.push_back(r);
        cmd_issued++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          c = pend_q.pop_front();
          cmd_if.valid      <= 1'b1;
          cmd_if.mode       <= c.mode;
          cmd_if.value      <= c.value;
          cmd_if.offset     <= c.offset;
          cmd_if.roll_count <= c.roll_count;
          cmd_if.new_depth  <= c.new_depth;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Check response beats against the oldest prediction; stall at random
  always @(posedge clk) begin : rsp_monitor
    stack_rsp_t e;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_expect_q.size() == 0) begin
          $display("%0t ns: response beat with nothing expected, actual depth %0d status %0d",
                   $time, rsp_if.depth, rsp_if.status);
          mismatch_cnt++;
        end else begin
          e = rsp_expect_q.pop_front();
          check_field("read_data", e.read_data, rsp_if.read_data);
          check_field("top_word", e.top_word, rsp_if.top_word);
          check_field("second_word", e.second_word, rsp_if.second_word);
          check_field("depth", e.depth, rsp_if.depth);
          check_field("status", e.status, rsp_if.status);
          rsp_checked++;
          status_seen[rsp_if.status]++;
        end
      end
      rsp_if.ready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int i;
    rst_n             = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.mode       = '0;
    cmd_if.value      = '0;
    cmd_if.offset     = '0;
    cmd_if.roll_count = '0;
    cmd_if.new_depth  = '0;
    rsp_if.ready      = 1'b0;
    long_hold         = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    model_st          = '0;
    gen_st            = '0;
    gen_written       = 0;
    cmd_issued        = 0;
    rsp_checked       = 0;
    mismatch_cnt      = 0;
    for (i = 0; i < 4; i++) status_seen[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty stack: every read or write underflows, deep rolls are out of range
    queue_dir(MODE_POP, '0, 0, 0, 0);
    queue_dir(MODE_PICK, '0, 0, 0, 0);
    queue_dir(MODE_WR_TOP, '1, 0, 0, 0);
    queue_dir(MODE_WR_SEC, '1, 0, 0, 0);
    queue_dir(MODE_ROLL, '0, 0, 1, 0);
    queue_dir(MODE_ROLL, '0, 0, 0, 0);
    queue_dir(MODE_PUSH, '0, 0, 0, 0);
    queue_dir(MODE_WR_SEC, '1, 0, 0, 0);
    queue_dir(MODE_PUSH, '1, 0, 0, 0);
    queue_dir(MODE_PICK, '0, 1, 0, 0);
    // Fill to the brim, then overflow
    for (i = 2; i < DEPTH; i++) queue_dir(MODE_PUSH, $urandom, 0, 0, 0);
    queue_dir(MODE_PUSH, 32'h5a5a_a5a5, 0, 0, 0);
    queue_dir(MODE_PICK, '0, 15, 0, 0);
    queue_dir(MODE_ROLL, '0, 0, 15, 0);
    queue_dir(MODE_ROLL, '0, 0, -15, 0);
    queue_dir(MODE_WR_TOP, '0, 0, 0, 0);
    queue_dir(MODE_WR_SEC, '1, 0, 0, 0);
    // Depth beyond the store, then back down and up again
    queue_dir(MODE_SET_SP, '0, 0, 0, DEPTH + 1);
    queue_dir(MODE_SET_SP, '0, 0, 0, 31);
    queue_dir(MODE_SET_SP, '0, 0, 0, 5);
    queue_dir(MODE_PICK, '0, 5, 0, 0);
    queue_dir(MODE_ROLL, '0, 0, -5, 0);
    queue_dir(MODE_SET_SP, '0, 0, 0, DEPTH);
    queue_dir(MODE_POP, '0, 0, 0, 0);
    queue_dir(MODE_CLEAR, '1, 15, -15, DEPTH);
    queue_dir(MODE_SET_SP, '0, 0, 0, 0);

    // Random traffic under each idling pattern
    queue_random(400);
    while (pend_q.size() != 0) @(negedge clk);
    send_idle_pct = 69;
    queue_random(400);
    while (pend_q.size() != 0) @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 69;
    queue_random(400);
    while (pend_q.size() != 0) @(negedge clk);
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    queue_random(200);
    while (pend_q.size() != 0) @(negedge clk);

    // Hold the response side off long enough to back up the command side
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        long_hold <= 1'b1;
        repeat (300) @(negedge clk);
        long_hold <= 1'b0;
      end
    join_none
    queue_random(100);
    while (pend_q.size() != 0) @(negedge clk);
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    queue_random(100);

    // Drain, then give the pipeline a few spare cycles
    while (pend_q.size() != 0 || cmd_if.valid || rsp_expect_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Ran %0d stack commands, %0d responses checked, %0d mismatches.",
             cmd_issued, rsp_checked, mismatch_cnt);
    $display("Status mix: ok %0d, overflow %0d, underflow %0d, range %0d.",
             status_seen[ST_OK], status_seen[ST_OVER], status_seen[ST_UNDER],
             status_seen[ST_RANGE]);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
